FILE: src/spn_block_cipher_16_unit_assert.svh
// Assertion macros for the 16-bit SPN cipher unit.
// Used by the top level; expects clk and rst in scope.
`ifndef SPN_BLOCK_CIPHER_16_UNIT_ASSERT_SVH
`define SPN_BLOCK_CIPHER_16_UNIT_ASSERT_SVH

// Generic clocked check, disabled while in reset.
`define SPNC_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Fixed-latency check: each accepted beat (acc) must be followed by strobe at the offset set by lat.
`define SPNC_LATENCY(lbl, acc, strobe, lat, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (acc) |-> ##lat (strobe)) \
    else $error(msg);

`endif

FILE: src/spnc_pkg.sv
// Shared types, constants and round functions for the 16-bit SPN cipher.
// No dependencies.
`timescale 1ns / 1ps

package spnc_pkg;

  localparam int BLK_W      = 16;
  localparam int NUM_STAGES = 4;
  localparam int CFG_IDX_W  = 1;

  typedef logic [BLK_W-1:0]     blk_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [3:0]           nib_t;

  localparam cfg_idx_t REG_KEY = 1'b0;
  localparam cfg_idx_t REG_DIR = 1'b1;

  // Per-stage control: item direction and whether this stage is the outer
  // (key-whitened, no transpose) round for that direction.
  typedef struct packed {
    logic dir;
    logic outer;
  } stage_ctl_t;

  localparam nib_t SBOX_FWD [16] = '{
    4'hE, 4'h4, 4'hD, 4'h1, 4'h2, 4'hF, 4'hB, 4'h8,
    4'h3, 4'hA, 4'h6, 4'hC, 4'h5, 4'h9, 4'h0, 4'h7
  };

  localparam nib_t SBOX_INV [16] = '{
    4'hE, 4'h3, 4'h4, 4'h8, 4'h1, 4'hC, 4'hA, 4'hF,
    4'h7, 4'hD, 4'h9, 4'h6, 4'hB, 4'h2, 4'h0, 4'h5
  };

  function automatic blk_t sub_fwd(blk_t v);
    blk_t r;
    for (int n = 0; n < 4; n++) begin
      r[4*n +: 4] = SBOX_FWD[v[4*n +: 4]];
    end
    return r;
  endfunction

  function automatic blk_t sub_inv(blk_t v);
    blk_t r;
    for (int n = 0; n < 4; n++) begin
      r[4*n +: 4] = SBOX_INV[v[4*n +: 4]];
    end
    return r;
  endfunction

  // 4x4 bit transpose, positions counted from the MSB.
  function automatic blk_t transpose(blk_t v);
    blk_t r;
    for (int p = 0; p < 16; p++) begin
      r[15-p] = v[15 - ((p % 4) * 4 + p / 4)];
    end
    return r;
  endfunction

  // Rotate left by 4*n bits.
  function automatic blk_t rotl_nib(blk_t v, logic [1:0] n);
    blk_t r;
    case (n)
      2'd0:    r = v;
      2'd1:    r = {v[11:0], v[15:12]};
      2'd2:    r = {v[7:0],  v[15:8]};
      default: r = {v[3:0],  v[15:4]};
    endcase
    return r;
  endfunction

endpackage

FILE: src/spnc_stage.sv
// One registered round of the SPN cipher, encrypt or decrypt per beat.
// Depends on spnc_pkg.
`timescale 1ns / 1ps

module spnc_stage
  import spnc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  stage_ctl_t ctl,
  input  blk_t       in_data,
  input  blk_t       key_a,
  input  blk_t       key_b,
  output logic       out_valid,
  output logic       out_dir,
  output blk_t       out_data
);

  blk_t enc_sub;
  blk_t dec_pre;
  blk_t data_next;

  // Encrypt: xor key_a, S-box, then transpose or (outer) xor key_b.
  // Decrypt: xor key_a (outer) or transpose, inverse S-box, xor key_b.
  always_comb begin
    enc_sub = sub_fwd(in_data ^ key_a);
    dec_pre = ctl.outer ? (in_data ^ key_a) : transpose(in_data);
    if (ctl.dir) begin
      data_next = sub_inv(dec_pre) ^ key_b;
    end else begin
      data_next = ctl.outer ? (enc_sub ^ key_b) : transpose(enc_sub);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_dir  <= ctl.dir;
    out_data <= data_next;
  end

endmodule

FILE: src/spn_block_cipher_16_unit.sv
`timescale 1ns / 1ps
// 16-bit SPN block cipher, fully pipelined: one round per stage, four
// stages. A block is taken on any cycle with start high (busy stays low),
// and its result appears with done after the four round registers, which
// set the latency; the unit sustains one block per clock. done is a
// one-cycle strobe; the receiver cannot stall, so results must be captured
// when shown. The user must write cipher_key and direction through the cfg
// port only while no block is in flight; the unit does not enforce it.
// direction travels with each beat. Depends on spnc_pkg and spnc_stage.
`include "spn_block_cipher_16_unit_assert.svh"

module spn_block_cipher_16_unit
  import spnc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [BLK_W-1:0]     block_in,
  output logic                 done,
  output logic [BLK_W-1:0]     block_out,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BLK_W-1:0]     cfg_wdata
);

  blk_t cipher_key;
  logic direction;

  logic v   [NUM_STAGES+1];
  logic d   [NUM_STAGES+1];
  blk_t x   [NUM_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key <= '0;
      direction  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY: cipher_key <= cfg_wdata;
        REG_DIR: direction  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Pipeline never stalls.
  assign busy = 1'b0;

  assign v[0] = start;
  assign d[0] = direction;
  assign x[0] = block_in;

  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    localparam logic IS_FIRST = (s == 0);
    localparam logic IS_LAST  = (s == NUM_STAGES - 1);

    stage_ctl_t ctl;
    blk_t       key_a;
    blk_t       key_b;

    // Encrypt uses round key s then the raw key; decrypt starts from the
    // raw key and walks the rotations back down.
    always_comb begin
      ctl.dir   = d[s];
      ctl.outer = d[s] ? IS_FIRST : IS_LAST;
      key_a     = d[s] ? cipher_key : rotl_nib(cipher_key, 2'(s));
      key_b     = d[s] ? rotl_nib(cipher_key, 2'(NUM_STAGES - 1 - s)) : cipher_key;
    end

    spnc_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_valid (v[s]),
      .ctl      (ctl),
      .in_data  (x[s]),
      .key_a    (key_a),
      .key_b    (key_b),
      .out_valid(v[s+1]),
      .out_dir  (d[s+1]),
      .out_data (x[s+1])
    );
  end

  assign done      = v[NUM_STAGES];
  assign block_out = x[NUM_STAGES];

  `SPNC_LATENCY(a_lat_fixed, start && !busy, done, 4, "accepted beat did not leave on time")
  `SPNC_CHECK(a_no_ghost, done |-> ($past(start, 4) && !$past(rst, 4)), "result without a beat")
  `SPNC_CHECK(a_dir_kept, done |-> (d[NUM_STAGES] == $past(direction, 4)), "direction lost")

endmodule
